// ===== hdl/i2c_dac_write_master_unit_macros.svh =====
// assertion macros shared by the i2c dac write master
`ifndef I2C_DAC_WRITE_MASTER_UNIT_MACROS_SVH
`define I2C_DAC_WRITE_MASTER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define I2CDW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cdw assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define I2CDW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cdw assertion failed");

`endif

// ===== hdl/i2cdw_pkg.sv =====
// shared types and constants of the i2c dac write master
`timescale 1ns / 1ps

package i2cdw_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam int ADDR_W   = 7;
  localparam int CMD_W    = 8;
  localparam int TICKS_W  = 16;
  localparam int CODE_W   = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_BYTE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 2'd2;

  localparam logic [ADDR_W-1:0]  ADDR_RST  = 7'h0C;
  localparam logic [CMD_W-1:0]   CMD_RST   = 8'h3F;
  localparam logic [TICKS_W-1:0] TICKS_RST = 16'd5;

  typedef struct packed {
    logic [ADDR_W-1:0]  device_address;
    logic [CMD_W-1:0]   command_byte;
    logic [TICKS_W-1:0] phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic scl_line;
    logic sda_drive;
    logic busy_res;
    logic done_res;
    logic ack_ok;
  } res_t;

endpackage

// ===== hdl/i2cdw_if.sv =====
// request and result channel interfaces of the i2c dac write master
`timescale 1ns / 1ps

interface i2cdw_in_if;
  logic                          valid;
  logic                          ready;
  logic                          start_req;
  logic [i2cdw_pkg::CODE_W-1:0]  code;
  logic                          sda_in;

  modport source (output valid, start_req, code, sda_in, input ready);
  modport sink   (input valid, start_req, code, sda_in, output ready);
endinterface

interface i2cdw_out_if;
  logic valid;
  logic ready;
  logic scl_line;
  logic sda_drive;
  logic busy_res;
  logic done_res;
  logic ack_ok;

  modport source (output valid, scl_line, sda_drive, busy_res, done_res, ack_ok,
                  input ready);
  modport sink   (input valid, scl_line, sda_drive, busy_res, done_res, ack_ok,
                  output ready);
endinterface

// ===== hdl/i2cdw_core.sv =====
// bus sequencer: phase state, delay counter and byte shifter, one step per tick
`timescale 1ns / 1ps

module i2cdw_core #(
  parameter int COUNT_WIDTH = i2cdw_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  logic                         start_req,
  input  logic [i2cdw_pkg::CODE_W-1:0] code,
  input  logic                         sda_in,
  input  i2cdw_pkg::cfg_t              cfg,
  output i2cdw_pkg::res_t              res
);

  `include "i2c_dac_write_master_unit_macros.svh"

  localparam int CMP_W = ((COUNT_WIDTH > i2cdw_pkg::TICKS_W) ?
                          COUNT_WIDTH : i2cdw_pkg::TICKS_W) + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ST_A  = 4'd1,
    PH_ST_B  = 4'd2,
    PH_ST_C  = 4'd3,
    PH_BIT_D = 4'd4,
    PH_BIT_H = 4'd5,
    PH_BIT_L = 4'd6,
    PH_ACK_R = 4'd7,
    PH_ACK_H = 4'd8,
    PH_ACK_L = 4'd9,
    PH_SP_A  = 4'd10,
    PH_SP_B  = 4'd11,
    PH_SP_C  = 4'd12
  } phase_t;

  phase_t                        phase_r, phase_nxt, enter_ph;
  logic [COUNT_WIDTH-1:0]        delay_r, delay_nxt;
  logic [1:0]                    byte_r, byte_nxt;
  logic [2:0]                    bit_r, bit_nxt;
  logic [7:0]                    shift_r, shift_nxt;
  logic [i2cdw_pkg::CODE_W-1:0]  code_r, code_nxt;
  logic                          nack_r, nack_nxt;
  logic                          scl_r, scl_nxt;
  logic                          sda_r, sda_nxt;
  logic                          enter, end_phase, done, ok;
  logic [i2cdw_pkg::TICKS_W-1:0] ticks;

  function automatic logic [7:0] byte_for(input logic [1:0] idx,
                                          input i2cdw_pkg::cfg_t c,
                                          input logic [i2cdw_pkg::CODE_W-1:0] cl);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = {c.device_address, 1'b0};
      2'd1:    b = c.command_byte;
      2'd2:    b = cl[11:4];
      default: b = {cl[3:0], 4'b0000};
    endcase
    return b;
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    delay_nxt = delay_r;
    byte_nxt  = byte_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    code_nxt  = code_r;
    nack_nxt  = nack_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    enter     = 1'b0;
    enter_ph  = phase_r;
    done      = 1'b0;
    ok        = 1'b0;
    ticks     = (cfg.phase_ticks == '0) ? i2cdw_pkg::TICKS_W'(1) : cfg.phase_ticks;
    end_phase = ((CMP_W'(delay_r) + CMP_W'(1)) >= CMP_W'(ticks)) || (delay_r == CNT_MAX);

    if (phase_r == PH_IDLE) begin
      if (start_req) begin
        code_nxt = code;
        nack_nxt = 1'b0;
        byte_nxt = 2'd0;
        bit_nxt  = 3'd0;
        enter    = 1'b1;
        enter_ph = PH_ST_A;
      end
    end else if (end_phase) begin
      enter = 1'b1;
      unique case (phase_r)
        PH_ST_A:  enter_ph = PH_ST_B;
        PH_ST_B:  enter_ph = PH_ST_C;
        PH_ST_C: begin
          byte_nxt  = 2'd0;
          bit_nxt   = 3'd0;
          shift_nxt = byte_for(2'd0, cfg, code_r);
          enter_ph  = PH_BIT_D;
        end
        PH_BIT_D: enter_ph = PH_BIT_H;
        PH_BIT_H: enter_ph = PH_BIT_L;
        PH_BIT_L: begin
          shift_nxt = {shift_r[6:0], 1'b0};
          if (bit_r == 3'd7) begin
            bit_nxt  = 3'd0;
            enter_ph = PH_ACK_R;
          end else begin
            bit_nxt  = bit_r + 3'd1;
            enter_ph = PH_BIT_D;
          end
        end
        PH_ACK_R: enter_ph = PH_ACK_H;
        PH_ACK_H: begin
          if (sda_in) begin
            nack_nxt = 1'b1;
          end
          enter_ph = PH_ACK_L;
        end
        PH_ACK_L: begin
          if (byte_r == 2'd3) begin
            enter_ph = PH_SP_A;
          end else begin
            byte_nxt  = byte_r + 2'd1;
            bit_nxt   = 3'd0;
            shift_nxt = byte_for(byte_r + 2'd1, cfg, code_r);
            enter_ph  = PH_BIT_D;
          end
        end
        PH_SP_A:  enter_ph = PH_SP_B;
        PH_SP_B:  enter_ph = PH_SP_C;
        PH_SP_C: begin
          done     = 1'b1;
          ok       = ~nack_r;
          enter_ph = PH_IDLE;
        end
        default:  enter_ph = PH_IDLE;
      endcase
    end else begin
      delay_nxt = delay_r + COUNT_WIDTH'(1);
    end

    if (enter) begin
      phase_nxt = enter_ph;
      delay_nxt = '0;
      unique case (enter_ph)
        PH_ST_A: begin
          sda_nxt = 1'b1;
          scl_nxt = 1'b1;
        end
        PH_ST_B:  sda_nxt = 1'b0;
        PH_ST_C:  scl_nxt = 1'b0;
        PH_BIT_D: sda_nxt = shift_nxt[7];
        PH_BIT_H: scl_nxt = 1'b1;
        PH_BIT_L: scl_nxt = 1'b0;
        PH_ACK_R: sda_nxt = 1'b1;
        PH_ACK_H: scl_nxt = 1'b1;
        PH_ACK_L: scl_nxt = 1'b0;
        PH_SP_A:  sda_nxt = 1'b0;
        PH_SP_B:  scl_nxt = 1'b1;
        PH_SP_C:  sda_nxt = 1'b1;
        default: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      delay_r <= '0;
      byte_r  <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      code_r  <= '0;
      nack_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      delay_r <= delay_nxt;
      byte_r  <= byte_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      code_r  <= code_nxt;
      nack_r  <= nack_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
    end
  end

  assign res.scl_line  = scl_nxt;
  assign res.sda_drive = sda_nxt;
  assign res.busy_res  = (phase_nxt != PH_IDLE);
  assign res.done_res  = done;
  assign res.ack_ok    = ok;

  `I2CDW_ASSERT_NOW(a_idle_lines_high, phase_r == PH_IDLE, scl_r && sda_r)
  `I2CDW_ASSERT_NOW(a_idle_count_zero, phase_r == PH_IDLE, delay_r == '0)
  `I2CDW_ASSERT_NEXT(a_start_latch, step_en && phase_r == PH_IDLE && start_req,
                     phase_r == PH_ST_A && code_r == $past(code))
  `I2CDW_ASSERT_NEXT(a_hold_no_step, !step_en, $stable(phase_r) && $stable(delay_r))
  `I2CDW_ASSERT_NOW(a_done_from_stop, done, phase_r == PH_SP_C && !res.busy_res)

endmodule

// ===== hdl/i2c_dac_write_master_unit.sv =====
// top level of the i2c dac write master: config registers, handshake, result register
`timescale 1ns / 1ps

// Each request on in_ch is one tick of the bus time base and yields exactly one
// result on out_ch: the SCL and SDA levels, busy, and a done pulse with the ACK
// status, all as they stand after that tick. A request is taken every clock
// cycle while out_ch accepts results: the sequencer step is a single pass of
// logic between the state registers and the result register, and in_ch.ready
// stays high whenever the result register is empty or being drained in the
// same cycle, so throughput is one request per cycle without back-pressure.
// A start while busy is ignored; each line phase lasts phase_ticks requests
// (zero counts as one). Configuration writes are meant for idle periods.

module i2c_dac_write_master_unit #(
  parameter int COUNT_WIDTH = i2cdw_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  i2cdw_in_if.sink                         in_ch,
  i2cdw_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [i2cdw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cdw_pkg::CFG_DATA_W-1:0] cfg_data
);

  i2cdw_pkg::cfg_t cfg_r;
  i2cdw_pkg::res_t res, res_r;
  logic            out_valid_r, out_valid_nxt;
  logic            step_en;

  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign step_en       = in_ch.valid && in_ch.ready;
  assign out_valid_nxt = step_en || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= i2cdw_pkg::ADDR_RST;
      cfg_r.command_byte   <= i2cdw_pkg::CMD_RST;
      cfg_r.phase_ticks    <= i2cdw_pkg::TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cdw_pkg::CFG_DEVICE_ADDRESS:
          cfg_r.device_address <= cfg_data[i2cdw_pkg::ADDR_W-1:0];
        i2cdw_pkg::CFG_COMMAND_BYTE:
          cfg_r.command_byte <= cfg_data[i2cdw_pkg::CMD_W-1:0];
        i2cdw_pkg::CFG_PHASE_TICKS:
          cfg_r.phase_ticks <= cfg_data[i2cdw_pkg::TICKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  i2cdw_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .start_req(in_ch.start_req),
    .code     (in_ch.code),
    .sda_in   (in_ch.sda_in),
    .cfg      (cfg_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl_line  = res_r.scl_line;
  assign out_ch.sda_drive = res_r.sda_drive;
  assign out_ch.busy_res  = res_r.busy_res;
  assign out_ch.done_res  = res_r.done_res;
  assign out_ch.ack_ok    = res_r.ack_ok;

endmodule
